>>> hdl/asidf_pkg.sv
package asidf_pkg;

    localparam int ENTRIES_DEF     = 512;
    localparam int TOTAL_SHIFT_DEF = 40;

    localparam int IDENT_W = 49;
    localparam int OWNER_W = 32;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_RESP
    } seq_state_t;

    // Write and read strobes from the sequencer to the entry tables.
    typedef struct packed {
        logic used_wr_en;
        logic used_wr_data;
        logic used_rd_en;
        logic owner_wr_en;
    } mem_ctl_t;

endpackage

>>> hdl/asidf_used_mem.sv
module asidf_used_mem #(
    parameter int ENTRIES = asidf_pkg::ENTRIES_DEF,
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic             wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic             rd_data
);

    logic mark_mem [ENTRIES];
    logic rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mark_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mark_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/asidf_seq.sv
module asidf_seq #(
    parameter int ENTRIES     = asidf_pkg::ENTRIES_DEF,
    parameter int TOTAL_SHIFT = asidf_pkg::TOTAL_SHIFT_DEF,
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int PTR_W      = $clog2(ENTRIES + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         func,
    input  logic [asidf_pkg::IDENT_W-1:0] release_ident,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [asidf_pkg::IDENT_W-1:0] ident_out,
    output logic                         status,
    output asidf_pkg::mem_ctl_t          mem_ctl,
    output logic [IDX_W-1:0]             mem_addr,
    input  logic                         used_rd_data
);

    localparam int WIDE_W = asidf_pkg::IDENT_W + TOTAL_SHIFT + IDX_W;

    asidf_pkg::seq_state_t state_reg, state_next;

    logic [PTR_W-1:0]              ptr_reg, ptr_next;
    logic [asidf_pkg::IDENT_W-1:0] ident_reg, ident_next;
    logic                          status_reg, status_next;

    logic                          accept;
    logic                          is_alloc;
    logic                          alloc_ok;
    logic                          ptr_at_end;
    logic                          clear_last;
    logic [PTR_W-1:0]              ptr_inc;
    logic [IDX_W-1:0]              ptr_idx;
    logic [asidf_pkg::IDENT_W-1:0] rel_full;
    logic                          rel_ok;
    logic [IDX_W-1:0]              rel_idx;
    logic [WIDE_W-1:0]             ident_wide;

    assign accept     = in_valid && in_ready;
    assign is_alloc   = (func == asidf_pkg::FUNC_ALLOC);
    assign ptr_at_end = (ptr_reg == PTR_W'(ENTRIES));
    assign alloc_ok   = !ptr_at_end;
    assign clear_last = (ptr_reg == PTR_W'(ENTRIES - 1));
    // The one incrementer serves the clearing pass and the free-entry scan.
    assign ptr_inc    = ptr_reg + PTR_W'(1);
    assign ptr_idx    = ptr_reg[IDX_W-1:0];
    assign rel_full   = release_ident >> TOTAL_SHIFT;
    assign rel_ok     = (rel_full < asidf_pkg::IDENT_W'(ENTRIES));
    assign rel_idx    = rel_full[IDX_W-1:0];
    assign ident_wide = WIDE_W'(ptr_idx) << TOTAL_SHIFT;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            asidf_pkg::ST_CLEAR: begin
                if (clear_last) begin
                    state_next = asidf_pkg::ST_IDLE;
                end
            end
            asidf_pkg::ST_IDLE: begin
                if (accept) begin
                    if (is_alloc && alloc_ok) begin
                        state_next = asidf_pkg::ST_SCAN;
                    end else begin
                        state_next = asidf_pkg::ST_RESP;
                    end
                end
            end
            asidf_pkg::ST_SCAN: begin
                if (ptr_at_end) begin
                    state_next = asidf_pkg::ST_RESP;
                end else begin
                    state_next = asidf_pkg::ST_CHECK;
                end
            end
            asidf_pkg::ST_CHECK: begin
                if (used_rd_data) begin
                    state_next = asidf_pkg::ST_SCAN;
                end else begin
                    state_next = asidf_pkg::ST_RESP;
                end
            end
            asidf_pkg::ST_RESP: begin
                if (out_ready) begin
                    state_next = asidf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = asidf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        mem_ctl   = '0;
        mem_addr  = ptr_idx;
        case (state_reg)
            asidf_pkg::ST_CLEAR: begin
                mem_ctl.used_wr_en   = 1'b1;
                mem_ctl.used_wr_data = 1'b0;
            end
            asidf_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (is_alloc) begin
                        mem_ctl.used_wr_en   = alloc_ok;
                        mem_ctl.used_wr_data = 1'b1;
                        mem_ctl.owner_wr_en  = alloc_ok;
                    end else begin
                        mem_addr             = rel_idx;
                        mem_ctl.used_wr_en   = rel_ok;
                        mem_ctl.used_wr_data = 1'b0;
                    end
                end
            end
            asidf_pkg::ST_SCAN: begin
                mem_ctl.used_rd_en = !ptr_at_end;
            end
            asidf_pkg::ST_CHECK: begin
            end
            asidf_pkg::ST_RESP: begin
                out_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        ptr_next    = ptr_reg;
        ident_next  = ident_reg;
        status_next = status_reg;
        case (state_reg)
            asidf_pkg::ST_CLEAR: begin
                ptr_next = clear_last ? '0 : ptr_inc;
            end
            asidf_pkg::ST_IDLE: begin
                if (accept) begin
                    ident_next  = '0;
                    status_next = asidf_pkg::STATUS_DONE;
                    if (is_alloc) begin
                        if (alloc_ok) begin
                            ident_next = ident_wide[asidf_pkg::IDENT_W-1:0];
                            ptr_next   = ptr_inc;
                        end else begin
                            status_next = asidf_pkg::STATUS_FULL;
                        end
                    end else if (rel_ok && (PTR_W'(rel_idx) < ptr_reg)) begin
                        ptr_next = PTR_W'(rel_idx);
                    end
                end
            end
            asidf_pkg::ST_CHECK: begin
                if (used_rd_data) begin
                    ptr_next = ptr_inc;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= asidf_pkg::ST_CLEAR;
            ptr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
        end
        ident_reg  <= ident_next;
        status_reg <= status_next;
    end

    assign ident_out = ident_reg;
    assign status    = status_reg;

endmodule

>>> hdl/asid_first_free_allocator_core.sv
// Lowest-free-index allocator for address-space identifiers. An allocate
// transfer (s_tuser = 0) takes the entry at the first-free pointer, marks it
// used, stores the owner handle, and returns the entry index shifted left by
// TOTAL_SHIFT (kept to 49 bits) with status 0; when every entry is in use it
// returns identifier 0 with status 1 and changes nothing. A release transfer
// (s_tuser = 1) frees the entry whose index sits above TOTAL_SHIFT in the
// given identifier, pulls the pointer down to it if it is lower, and returns
// identifier 0 with status 0; an index beyond the table is ignored. Exactly one
// result transfer follows each input transfer, and one item is handled at a
// time. A granted allocation then scans forward for the next free entry and
// stops there or at the table end; the scan reads the used-mark memory
// through its single registered read port and advances the shared pointer
// incrementer one entry at a time. Each result is held until m_tready. After
// reset the used marks are cleared by a pass over all ENTRIES entries (512 by
// default), during which s_tready stays low.
module asid_first_free_allocator_core #(
    parameter int ENTRIES     = asidf_pkg::ENTRIES_DEF,
    parameter int TOTAL_SHIFT = asidf_pkg::TOTAL_SHIFT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: owner_id [31:0], release_ident [80:32], zero fill [87:81]
    input  logic [87:0] s_tdata,
    // s_tuser: func [0]
    input  logic        s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: ident_out [48:0], zero fill [55:49]
    output logic [55:0] m_tdata,
    // m_tuser: status [0]
    output logic        m_tuser
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [asidf_pkg::OWNER_W-1:0] owner_id;
    logic [asidf_pkg::IDENT_W-1:0] release_ident;
    logic [asidf_pkg::IDENT_W-1:0] ident_out;
    logic                          status;
    asidf_pkg::mem_ctl_t           mem_ctl;
    logic [IDX_W-1:0]              mem_addr;
    logic                          used_rd_data;

    // The owner table is kept for software bookkeeping; nothing in the
    // result path reads it back.
    logic [asidf_pkg::OWNER_W-1:0] owner_mem [ENTRIES];

    assign owner_id      = s_tdata[asidf_pkg::OWNER_W-1:0];
    assign release_ident = s_tdata[asidf_pkg::OWNER_W +: asidf_pkg::IDENT_W];

    asidf_seq #(
        .ENTRIES     (ENTRIES),
        .TOTAL_SHIFT (TOTAL_SHIFT)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .func          (s_tuser),
        .release_ident (release_ident),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .ident_out     (ident_out),
        .status        (status),
        .mem_ctl       (mem_ctl),
        .mem_addr      (mem_addr),
        .used_rd_data  (used_rd_data)
    );

    asidf_used_mem #(
        .ENTRIES (ENTRIES)
    ) u_used_mem (
        .aclk    (aclk),
        .wr_en   (mem_ctl.used_wr_en),
        .wr_addr (mem_addr),
        .wr_data (mem_ctl.used_wr_data),
        .rd_en   (mem_ctl.used_rd_en),
        .rd_addr (mem_addr),
        .rd_data (used_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (mem_ctl.owner_wr_en) begin
            owner_mem[mem_addr] <= owner_id;
        end
    end

    assign m_tdata = {{(56 - asidf_pkg::IDENT_W){1'b0}}, ident_out};
    assign m_tuser = status;

endmodule

>>> tb/sv/testbench.sv
// Self-checking bench for the first-free identifier allocator.
//
// The stimulus runs through four phases. A short directed opening hits the
// field extremes, a release below the pointer, a repeated release of an entry
// that is already free, and allocations that have to scan over used entries.
// An allocation-heavy phase then fills the whole table. Once every result of
// that phase is back, the table is probed while full: refused allocations,
// a release of the top entry and its reallocation, where the scan runs into
// the table end. A balanced mix of allocations and releases closes the run,
// and its last stretch has no idling on either side.
//
// A ledger object keeps its own copy of the used marks and the first-free
// pointer. It works out the expected result of every input transfer and
// compares every result transfer against the oldest pending expectation.
module testbench;

    localparam int ENTRIES     = asidf_pkg::ENTRIES_DEF;
    localparam int TOTAL_SHIFT = asidf_pkg::TOTAL_SHIFT_DEF;
    localparam int IDENT_W     = asidf_pkg::IDENT_W;
    localparam int OWNER_W     = asidf_pkg::OWNER_W;

    // Generous cap on the run length. A granted allocation costs at most a scan
    // over the whole table, plus the longest gap and stall on each side.
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int ITEM_TARGET = 650;
    localparam int QUIET_TAIL  = 50;

    typedef struct {
        logic               func;
        logic [OWNER_W-1:0] owner;
        logic [IDENT_W-1:0] rel_ident;
    } asid_req_t;

    typedef struct {
        logic [IDENT_W-1:0] ident;
        logic               status;
    } asid_rsp_t;

    // Predicts the allocator and checks its results in order.
    class asid_ledger;
        bit          used [ENTRIES];
        int unsigned next_free;
        asid_rsp_t   pending_q [$];
        int unsigned mismatches;
        int unsigned granted;
        int unsigned refused;
        int unsigned releases;
        int unsigned checked;

        function new();
            next_free  = 0;
            mismatches = 0;
            granted    = 0;
            refused    = 0;
            releases   = 0;
            checked    = 0;
            foreach (used[i]) used[i] = 1'b0;
        endfunction

        function void note_request(asid_req_t r);
            asid_rsp_t   rsp;
            logic [63:0] wide;
            rsp.ident  = '0;
            rsp.status = asidf_pkg::STATUS_DONE;
            if (r.func == asidf_pkg::FUNC_ALLOC) begin
                if (next_free < ENTRIES) begin
                    wide      = 64'(next_free) << TOTAL_SHIFT;
                    rsp.ident = wide[IDENT_W-1:0];
                    used[next_free] = 1'b1;
                    // Scan forward to the next free entry, stopping at the end.
                    do next_free++;
                    while (next_free < ENTRIES && used[next_free]);
                    granted++;
                end else begin
                    rsp.status = asidf_pkg::STATUS_FULL;
                    refused++;
                end
            end else begin
                wide = 64'(r.rel_ident) >> TOTAL_SHIFT;
                if (wide < ENTRIES) begin
                    used[wide] = 1'b0;
                    if (wide < next_free) next_free = int'(wide);
                end
                releases++;
            end
            pending_q.push_back(rsp);
        endfunction

        function void check_result(logic [IDENT_W-1:0] ident, logic status);
            asid_rsp_t exp_rsp;
            if (pending_q.size() == 0) begin
                $display("%0t: result with nothing pending: ident %h status %b",
                         $time, ident, status);
                mismatches++;
                return;
            end
            exp_rsp = pending_q.pop_front();
            checked++;
            if (ident !== exp_rsp.ident) begin
                $display("%0t: ident mismatch: expected %h, actual %h",
                         $time, exp_rsp.ident, ident);
                mismatches++;
            end
            if (status !== exp_rsp.status) begin
                $display("%0t: status mismatch: expected %b, actual %b",
                         $time, exp_rsp.status, status);
                mismatches++;
            end
        endfunction

        // A random entry that is currently in use, or a random index if none
        // turns up after a few tries.
        function int unsigned pick_used();
            int unsigned idx;
            idx = $urandom_range(ENTRIES - 1);
            for (int t = 0; t < 16; t++) begin
                idx = $urandom_range(ENTRIES - 1);
                if (used[idx]) break;
            end
            return idx;
        endfunction
    endclass

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [87:0]        s_tdata   = '0;
    logic               s_tuser   = asidf_pkg::FUNC_ALLOC;
    logic               m_tvalid;
    logic               m_tready  = 1'b1;
    logic [55:0]        m_tdata;
    logic               m_tuser;

    asid_ledger  ledger = new();
    int unsigned cycle_count  = 0;
    int unsigned items_sent   = 0;
    bit          idling_on    = 1'b1;
    int unsigned tx_gap_pct   = 0;
    int unsigned rx_stall_pct = 0;

    asid_first_free_allocator_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Both channels are sampled at the rising edge. Inputs only ever change
    // at the falling edge, so the values seen here are stable.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                ledger.note_request('{func: s_tuser, owner: s_tdata[31:0],
                                      rel_ident: s_tdata[80:32]});
            end
            if (m_tvalid && m_tready) begin
                ledger.check_result(m_tdata[IDENT_W-1:0], m_tuser);
            end
        end
    end

    // Result side back-pressure: random stall bursts hold m_tready low. The
    // stall rate changes per stretch of items and may be zero for a while.
    initial begin
        forever begin
            @(negedge aclk);
            if (idling_on && $urandom_range(99) < rx_stall_pct) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge aclk);
                m_tready = 1'b1;
            end
        end
    end

    // Picks how busy both sides are for the next stretch of items.
    task automatic choose_pace();
        if ($urandom_range(2) == 0) begin
            tx_gap_pct   = 0;
            rx_stall_pct = 0;
        end else begin
            tx_gap_pct   = $urandom_range(10, 40);
            rx_stall_pct = $urandom_range(5, 25);
        end
    endtask

    // Called at a falling edge. Presents one request, holds it until the
    // transfer happens, and returns at the following falling edge with valid
    // still high; the caller either presents the next request or drops valid.
    task automatic send_request(input asid_req_t r);
        if (idling_on && $urandom_range(99) < tx_gap_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = r.func;
        s_tdata  = {7'b0, r.rel_ident, r.owner};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
        if (items_sent % 40 == 0) choose_pace();
    endtask

    // Stops sending and waits until every pending result has come back.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        @(posedge aclk);
        while (ledger.pending_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [IDENT_W-1:0] rand_ident();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[IDENT_W-1:0];
    endfunction

    // Builds a release identifier for entry idx with arbitrary bits below the
    // shift, which the allocator must ignore.
    function automatic logic [IDENT_W-1:0] ident_for(int unsigned idx,
                                                     logic [IDENT_W-1:0] low);
        logic [63:0] wide;
        logic [63:0] low_mask;
        low_mask = (64'd1 << TOTAL_SHIFT) - 64'd1;
        wide     = (64'(idx) << TOTAL_SHIFT) | (64'(low) & low_mask);
        return wide[IDENT_W-1:0];
    endfunction

    function automatic asid_req_t alloc_req(logic [OWNER_W-1:0] owner);
        return '{func: asidf_pkg::FUNC_ALLOC, owner: owner, rel_ident: rand_ident()};
    endfunction

    function automatic asid_req_t release_req(logic [IDENT_W-1:0] ident);
        return '{func: asidf_pkg::FUNC_RELEASE, owner: $urandom, rel_ident: ident};
    endfunction

    initial begin
        int unsigned mix_items;
        int unsigned leftover;

        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        // The block clears its used marks after reset with s_tready low; the
        // first transfer simply waits for it.

        // Directed opening.
        send_request(alloc_req('0));                     // gets entry 0
        send_request(alloc_req('1));                     // gets entry 1
        send_request(alloc_req($urandom));               // gets entry 2
        // Release entry 1 with every bit below the shift set: the pointer
        // drops from 3 to 1.
        send_request(release_req(ident_for(1, '1)));
        // Releasing the same, already free entry again changes nothing.
        send_request(release_req(ident_for(1, '0)));
        send_request(alloc_req($urandom));               // 1, then scans past 2
        // All-ones identifier: the top entry, which is free and above the
        // pointer.
        send_request(release_req('1));
        // All-zero identifier frees entry 0 and pulls the pointer to it.
        send_request(release_req('0));
        send_request(release_req('0));                   // free entry, equal
        send_request(alloc_req('1));                     // 0, scans over 1 and 2
        send_request(release_req(ident_for(2, rand_ident())));
        send_request(release_req(ident_for(1, rand_ident())));
        send_request(alloc_req($urandom));               // 1, stops on 2

        // Fill the table. Mostly allocations with random owners; a few
        // releases of used entries open holes that later scans have to skip.
        choose_pace();
        while (ledger.next_free < ENTRIES) begin
            if ($urandom_range(99) < 6) begin
                send_request(release_req(ident_for(ledger.pick_used(), rand_ident())));
            end else begin
                send_request(alloc_req($urandom));
            end
        end

        // Let everything settle before probing the full table.
        wait_drained();
        send_request(alloc_req($urandom));               // refused
        send_request(alloc_req('1));                     // refused
        send_request(release_req(ident_for(ENTRIES - 1, rand_ident())));
        send_request(alloc_req($urandom));               // top entry, scan ends
        send_request(alloc_req($urandom));               // refused again

        // Balanced mix; the last stretch runs without any idling.
        mix_items = (items_sent + 60 < ITEM_TARGET) ? ITEM_TARGET - items_sent : 60;
        for (int n = 0; n < mix_items; n++) begin
            if (n == mix_items - QUIET_TAIL) begin
                idling_on = 1'b0;
                m_tready  = 1'b1;
            end
            if ($urandom_range(1) == 0) begin
                send_request(alloc_req($urandom));
            end else if ($urandom_range(3) != 0) begin
                send_request(release_req(ident_for(ledger.pick_used(), rand_ident())));
            end else begin
                send_request(release_req(rand_ident()));
            end
        end

        wait_drained();
        // Nothing should be in flight; give the block a full scan's worth of
        // cycles to produce anything unexpected.
        repeat (2 * ENTRIES + 16) @(posedge aclk);
        leftover = ledger.pending_q.size();

        $display("Covered %0d transfers: %0d allocations granted, %0d refused on a full",
                 items_sent, ledger.granted, ledger.refused);
        $display("table, %0d releases; %0d results checked.", ledger.releases,
                 ledger.checked);
        if (ledger.mismatches == 0 && leftover == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
